// ===== hdl/imu_offset_calibrate_decimate_core_defines.svh =====
// -----------------------------------------------------------------------------
// imu_offset_calibrate_decimate_core_defines.svh
// Assertion macros shared by the IMU offset/decimate core.
// -----------------------------------------------------------------------------
`ifndef IMU_OFFSET_CALIBRATE_DECIMATE_CORE_DEFINES_SVH
`define IMU_OFFSET_CALIBRATE_DECIMATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IOCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IOCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/imu_ocd_pkg.sv =====
// -----------------------------------------------------------------------------
// imu_ocd_pkg
// Shared types and constants for the IMU offset/decimate core.
// -----------------------------------------------------------------------------
package imu_ocd_pkg;

    localparam int AXIS_W      = 16;
    localparam int SUM_W       = 24;
    localparam int CNT_W       = 8;
    localparam int CAL_SAMPLES = 200;
    localparam int NUM_AXES    = 3;

    // Reciprocal for exact floor(x / CAL_SAMPLES), x < 2**SUM_W.
    localparam int DIV_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W   = DIV_SHIFT;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic        [CNT_W-1:0]  cnt_t;
    typedef axis_t axis3_t [NUM_AXES];

    typedef struct packed {
        logic active;       // calibration running (registered)
        logic active_next;  // running after the current beat
        logic skip;         // beat zeroes or finishes: lower-priority step must wait
    } cal_stat_t;

endpackage

// ===== hdl/imu_ocd_div.sv =====
// -----------------------------------------------------------------------------
// imu_ocd_div
// Signed divide of a calibration sum by CAL_SAMPLES, truncating toward zero.
// -----------------------------------------------------------------------------
module imu_ocd_div
(
    input  imu_ocd_pkg::sum_t  sum,
    output imu_ocd_pkg::axis_t quo
);
    import imu_ocd_pkg::*;

    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  q;
    logic [AXIS_W-1:0] q16;

    always_comb
    begin
        neg  = sum[SUM_W-1];
        mag  = neg ? (SUM_W'(0) - SUM_W'(sum)) : SUM_W'(sum);
        // reciprocal multiply, exact over the full sum range
        prod = {{RECIP_W{1'b0}}, mag} * PROD_W'(DIV_RECIP);
        q    = prod[PROD_W-1:DIV_SHIFT];
        q16  = q[AXIS_W-1:0];
        quo  = neg ? axis_t'(AXIS_W'(0) - q16) : axis_t'(q16);
    end

endmodule

// ===== hdl/imu_ocd_cal.sv =====
// -----------------------------------------------------------------------------
// imu_ocd_cal
// Offset calibration engine for one three-axis sensor: zero, accumulate,
// divide, load offsets.
// -----------------------------------------------------------------------------
module imu_ocd_cal
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,       // beat accepted
    input  logic                   start,    // start request on this beat
    input  logic                   hold,     // step skipped on this beat
    input  imu_ocd_pkg::axis3_t    samples,  // corrected samples
    output imu_ocd_pkg::axis3_t    offsets,
    output imu_ocd_pkg::cal_stat_t stat
);
    import imu_ocd_pkg::*;

    axis_t  off_reg  [NUM_AXES];
    axis_t  off_next [NUM_AXES];
    sum_t   sum_reg  [NUM_AXES];
    sum_t   sum_next [NUM_AXES];
    sum_t   sum_acc  [NUM_AXES];
    axis_t  quo      [NUM_AXES];
    cnt_t   cnt_reg;
    cnt_t   cnt_next;
    logic   active_reg;
    logic   active_next;
    logic   act;
    logic   first;
    logic   done;

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_div
        assign sum_acc[i] = sum_reg[i]
                          + {{(SUM_W-AXIS_W){samples[i][AXIS_W-1]}}, samples[i]};
        imu_ocd_div u_div
        (
            .sum (sum_acc[i]),
            .quo (quo[i])
        );
    end

    always_comb
    begin
        act         = active_reg | (en & start);
        first       = (cnt_reg == '0);
        done        = (cnt_reg >= CNT_W'(CAL_SAMPLES));
        active_next = act;
        cnt_next    = cnt_reg;
        off_next    = off_reg;
        sum_next    = sum_reg;
        if (en && act && !hold)
        begin
            if (first)
            begin
                cnt_next = CNT_W'(1);
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    off_next[i] = '0;
                    sum_next[i] = '0;
                end
            end
            else
            begin
                sum_next = sum_acc;
                if (done)
                begin
                    off_next    = quo;
                    cnt_next    = '0;
                    active_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
        stat.active      = active_reg;
        stat.active_next = active_next;
        stat.skip        = act & (first | done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                off_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            off_reg    <= off_next;
            sum_reg    <= sum_next;
        end
    end

    assign offsets = off_reg;

endmodule

// ===== hdl/imu_offset_calibrate_decimate_core.sv =====
// -----------------------------------------------------------------------------
// imu_offset_calibrate_decimate_core
// Six-axis IMU offset correction, offset calibration and 2:1 decimation.
// -----------------------------------------------------------------------------
// Takes one six-axis sample per beat and accepts a beat in every cycle while
// the output register is empty or being drained. Each axis is corrected by
// its stored offset (wrapped to 16 bits); every second beat loads one result
// beat, the truncated average of the pair, into the output register on the
// edge that accepts the second sample, so it shows on m_tdata in the next
// cycle. Calibration requests ride in
// s_tuser: a calibration zeroes its offsets on its first beat, sums the next
// CAL_SAMPLES corrected beats and loads sum / CAL_SAMPLES (toward zero) on
// the last one; the divide is a constant-reciprocal multiply in the same
// cycle as the last accumulate, so new offsets apply from the very next beat.
// Gyro calibration has priority: on a beat where it zeroes or finishes, the
// accelerometer step waits. Accelerometer Z never accumulates and ends at
// zero. The busy flags in m_tuser show calibration state after the second
// beat of the pair. No clearing pass: everything is ready out of reset.
// -----------------------------------------------------------------------------
module imu_offset_calibrate_decimate_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // acc_x_raw, acc_y_raw, acc_z_raw, gyr_x_raw, gyr_y_raw, gyr_z_raw
    input  logic [95:0] s_tdata,
    // start_acc_cal, start_gyr_cal
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // acc_x_avg, acc_y_avg, acc_z_avg, gyr_x_avg, gyr_y_avg, gyr_z_avg
    output logic [95:0] m_tdata,
    // acc_cal_busy, gyr_cal_busy
    output logic [1:0]  m_tuser
);
    import imu_ocd_pkg::*;

    localparam int NUM_LANES = 2 * NUM_AXES;

    logic        accept;
    axis_t       corr      [NUM_LANES];
    axis_t       first_reg [NUM_LANES];
    axis_t       avg       [NUM_LANES];
    axis3_t      acc_off;
    axis3_t      gyr_off;
    axis3_t      acc_smp;
    axis3_t      gyr_smp;
    cal_stat_t   acc_stat;
    cal_stat_t   gyr_stat;
    logic        phase_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [95:0] out_data_reg;
    logic [95:0] out_data_next;
    logic [1:0]  out_user_reg;
    logic [1:0]  out_user_next;
    logic        gyr_start_beat;
    logic        acc_held_beat;
    logic        acc_kept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Offset correction, wrapped to 16 bits.
    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_corr
        assign corr[i] = axis_t'(s_tdata[i*AXIS_W +: AXIS_W] - acc_off[i]);
        assign corr[i+NUM_AXES] =
            axis_t'(s_tdata[(i+NUM_AXES)*AXIS_W +: AXIS_W] - gyr_off[i]);
        assign gyr_smp[i] = corr[i+NUM_AXES];
    end

    // Z is not summed: feed zero so its sum and offset stay zero.
    assign acc_smp[0] = corr[0];
    assign acc_smp[1] = corr[1];
    assign acc_smp[2] = '0;

    imu_ocd_cal u_gyr_cal
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .start   (s_tuser[1]),
        .hold    (1'b0),
        .samples (gyr_smp),
        .offsets (gyr_off),
        .stat    (gyr_stat)
    );

    imu_ocd_cal u_acc_cal
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .start   (s_tuser[0]),
        .hold    (gyr_stat.skip),
        .samples (acc_smp),
        .offsets (acc_off),
        .stat    (acc_stat)
    );

    // Pair average, truncated toward zero.
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_avg
        logic signed [AXIS_W:0] pair_sum;
        logic signed [AXIS_W:0] pair_adj;
        assign pair_sum = {first_reg[i][AXIS_W-1], first_reg[i]}
                        + {corr[i][AXIS_W-1], corr[i]};
        assign pair_adj = pair_sum + {{AXIS_W{1'b0}}, pair_sum[AXIS_W]};
        assign avg[i]   = pair_adj[AXIS_W:1];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (accept && phase_reg)
        begin
            out_valid_next = 1'b1;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                out_data_next[i*AXIS_W +: AXIS_W] = avg[i];
            end
            out_user_next = {gyr_stat.active_next, acc_stat.active_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                first_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= !phase_reg;
                if (!phase_reg)
                begin
                    first_reg <= corr;
                end
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Assertion terms.
    assign gyr_start_beat = accept && s_tuser[1] && !gyr_stat.active;
    assign acc_held_beat  = accept && gyr_stat.skip;
    assign acc_kept       = acc_stat.active_next == (acc_stat.active || s_tuser[0]);

`include "imu_offset_calibrate_decimate_core_defines.svh"

    `IOCD_ASSERT_NEXT(a_pair_emits, accept && phase_reg, m_tvalid, "second beat gave no result")
    `IOCD_ASSERT_NEXT(a_phase_flips, accept && !phase_reg, phase_reg, "pair phase stuck")
    `IOCD_ASSERT_NEXT(a_gyr_start, gyr_start_beat, gyr_stat.active, "gyro cal did not start")
    `IOCD_ASSERT_NOW(a_acc_wait, acc_held_beat, acc_kept, "accel step ran while gyro had priority")

endmodule

// ===== tb/imu_ocd_pair_mean_checker.sv =====
// -----------------------------------------------------------------------------
// imu_ocd_pair_mean_checker
// Predicts and checks pair means and calibration flags of the IMU core.
// -----------------------------------------------------------------------------
// Watches both stream channels. Every accepted sample beat is run through a
// local model of offset correction, gyro/accel calibration and pairing; each
// second sample queues one expected mean beat. Accepted output beats are
// compared field by field against the oldest queued mean.
// -----------------------------------------------------------------------------
module imu_ocd_pair_mean_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // acc_x_raw, acc_y_raw, acc_z_raw, gyr_x_raw, gyr_y_raw, gyr_z_raw
    input  logic [95:0] s_tdata,
    // start_acc_cal, start_gyr_cal
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // acc_x_avg, acc_y_avg, acc_z_avg, gyr_x_avg, gyr_y_avg, gyr_z_avg
    input  logic [95:0] m_tdata,
    // acc_cal_busy, gyr_cal_busy
    input  logic [1:0]  m_tuser,
    output int          mismatch_cnt,
    output int          means_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import imu_ocd_pkg::*;

    localparam int GYR_BASE = NUM_AXES;
    localparam int ALL_AXES = 2 * NUM_AXES;

    // [0..2] accel X/Y/Z, [3..5] gyro X/Y/Z
    typedef logic [ALL_AXES-1:0][AXIS_W-1:0] imu_words_t;

    typedef struct packed {
        logic gyr;
        logic acc;
    } cal_flags_t;

    typedef struct {
        imu_words_t mean;
        cal_flags_t busy;
    } pair_mean_t;

    axis_t      acc_off [NUM_AXES];
    axis_t      gyr_off [NUM_AXES];
    sum_t       acc_sum [2];        // Z is never summed
    sum_t       gyr_sum [NUM_AXES];
    cnt_t       acc_cnt;
    cnt_t       gyr_cnt;
    logic       acc_busy;
    logic       gyr_busy;
    logic       second_half;
    axis_t      first_half [ALL_AXES];
    pair_mean_t pair_means_q [$];

    string axis_label [ALL_AXES] = '{"acc_x", "acc_y", "acc_z", "gyr_x", "gyr_y", "gyr_z"};

    function automatic void clear_model();
        int i;
        for (i = 0; i < NUM_AXES; i++)
        begin
            acc_off[i] = '0;
            gyr_off[i] = '0;
            gyr_sum[i] = '0;
        end
        for (i = 0; i < ALL_AXES; i++)
            first_half[i] = '0;
        acc_sum[0]   = '0;
        acc_sum[1]   = '0;
        acc_cnt      = '0;
        gyr_cnt      = '0;
        acc_busy     = 1'b0;
        gyr_busy     = 1'b0;
        second_half  = 1'b0;
        mismatch_cnt = 0;
        means_owed   = 0;
        pair_means_q.delete();
    endfunction

    function automatic void take_sample(imu_words_t raw, cal_flags_t req);
        axis_t      fixed [ALL_AXES];
        logic       hold_acc;
        pair_mean_t m;
        int         i;
        hold_acc = 1'b0;
        if (req.acc)
            acc_busy = 1'b1;
        if (req.gyr)
            gyr_busy = 1'b1;

        // correction always uses the offsets held before this beat
        for (i = 0; i < NUM_AXES; i++)
        begin
            fixed[i]            = axis_t'(raw[i] - acc_off[i]);
            fixed[i + GYR_BASE] = axis_t'(raw[i + GYR_BASE] - gyr_off[i]);
        end

        // gyro first; its zeroing and finishing beats hold the accel step
        if (gyr_busy)
        begin
            if (gyr_cnt == '0)
            begin
                for (i = 0; i < NUM_AXES; i++)
                begin
                    gyr_off[i] = '0;
                    gyr_sum[i] = '0;
                end
                gyr_cnt  = cnt_t'(1);
                hold_acc = 1'b1;
            end
            else
            begin
                for (i = 0; i < NUM_AXES; i++)
                    gyr_sum[i] = gyr_sum[i] + fixed[i + GYR_BASE];
                if (gyr_cnt >= CAL_SAMPLES)
                begin
                    for (i = 0; i < NUM_AXES; i++)
                        gyr_off[i] = axis_t'(int'(gyr_sum[i]) / CAL_SAMPLES);
                    gyr_cnt  = '0;
                    gyr_busy = 1'b0;
                    hold_acc = 1'b1;
                end
                else
                    gyr_cnt = gyr_cnt + 1'b1;
            end
        end

        if (acc_busy && !hold_acc)
        begin
            if (acc_cnt == '0)
            begin
                for (i = 0; i < NUM_AXES; i++)
                    acc_off[i] = '0;
                acc_sum[0] = '0;
                acc_sum[1] = '0;
                acc_cnt    = cnt_t'(1);
            end
            else
            begin
                acc_sum[0] = acc_sum[0] + fixed[0];
                acc_sum[1] = acc_sum[1] + fixed[1];
                if (acc_cnt >= CAL_SAMPLES)
                begin
                    acc_off[0] = axis_t'(int'(acc_sum[0]) / CAL_SAMPLES);
                    acc_off[1] = axis_t'(int'(acc_sum[1]) / CAL_SAMPLES);
                    acc_off[2] = '0;
                    acc_cnt    = '0;
                    acc_busy   = 1'b0;
                end
                else
                    acc_cnt = acc_cnt + 1'b1;
            end
        end

        if (!second_half)
        begin
            first_half  = fixed;
            second_half = 1'b1;
            return;
        end

        second_half = 1'b0;
        for (i = 0; i < ALL_AXES; i++)
            m.mean[i] = axis_t'((int'(first_half[i]) + int'(fixed[i])) / 2);
        m.busy.acc = acc_busy;
        m.busy.gyr = gyr_busy;
        pair_means_q.push_back(m);
    endfunction

    function automatic void check_mean(imu_words_t got, cal_flags_t got_busy);
        pair_mean_t want;
        int         i;
        if (pair_means_q.size() == 0)
        begin
            mismatch_cnt++;
            $display("%0t: unexpected result beat, data %h busy %b", $time, got, got_busy);
            return;
        end
        want = pair_means_q.pop_front();
        for (i = 0; i < ALL_AXES; i++)
        begin
            if (got[i] !== want.mean[i])
            begin
                mismatch_cnt++;
                $display("%0t: %s_avg expected %0d, got %0d", $time, axis_label[i],
                         $signed(want.mean[i]), $signed(got[i]));
            end
        end
        if (got_busy.acc !== want.busy.acc)
        begin
            mismatch_cnt++;
            $display("%0t: acc_cal_busy expected %b, got %b", $time, want.busy.acc,
                     got_busy.acc);
        end
        if (got_busy.gyr !== want.busy.gyr)
        begin
            mismatch_cnt++;
            $display("%0t: gyr_cal_busy expected %b, got %b", $time, want.busy.gyr,
                     got_busy.gyr);
        end
    endfunction

    // sample beat is folded in first, so a same-edge mean would still find its entry
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_mean(m_tdata, m_tuser);
            means_owed = pair_means_q.size();
        end
    end

endmodule

// ===== tb/tb_imu_offset_calibrate_decimate_core.sv =====
// -----------------------------------------------------------------------------
// tb_imu_offset_calibrate_decimate_core
// Stream-level test of IMU offset correction, calibration and 2:1 decimation.
// -----------------------------------------------------------------------------
// Drives sample beats with random gaps and a randomly stalling result sink,
// including two long sink hold-offs that back the core up into its input.
// A short directed run covers corner words and truncation of odd pair sums,
// then random episodes run full accel/gyro calibrations (alone, together and
// staggered) on biased noisy data, mixed with free-running noise. The
// attached checker predicts every mean beat; this module gives the verdict.
// -----------------------------------------------------------------------------
module tb_imu_offset_calibrate_decimate_core;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_ocd_pkg::*;

    localparam int ITEM_GOAL    = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 160;
    localparam int ALL_AXES     = 2 * NUM_AXES;

    typedef logic [ALL_AXES-1:0][AXIS_W-1:0] imu_words_t;

    // Which calibrations an episode starts, and in what order.
    typedef enum {
        PLAN_ACC,
        PLAN_GYR,
        PLAN_BOTH,
        PLAN_ACC_THEN_GYR,
        PLAN_GYR_THEN_ACC
    } cal_plan_e;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;       // acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z raw words
    logic [1:0]  s_tuser;       // start_acc_cal, start_gyr_cal
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;       // acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z averages
    logic [1:0]  m_tuser;       // acc_cal_busy, gyr_cal_busy
    int          mismatch_cnt;
    int          means_owed;

    int          items_sent;
    logic        sender_burst;  // when set, the source offers beats back to back

    logic [AXIS_W-1:0] corner_words [4] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};

    imu_offset_calibrate_decimate_core u_top (.*);

    imu_ocd_pair_mean_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // One raw word near a center, with some corner words and some full-range noise.
    function automatic logic [AXIS_W-1:0] draw_word(logic [AXIS_W-1:0] center);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return corner_words[$urandom_range(0, 3)];
        if (pick < 20)
            return AXIS_W'($urandom);
        return center + AXIS_W'($urandom_range(0, 96)) - AXIS_W'(48);
    endfunction

    // Offer one sample beat; called at a falling edge, returns at a falling edge.
    task automatic push_sample(input imu_words_t words, input logic req_acc,
                               input logic req_gyr);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= words;
        s_tuser  <= {req_gyr, req_acc};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
        items_sent++;
    endtask

    task automatic push_noisy(input imu_words_t centers, input logic req_acc,
                              input logic req_gyr);
        imu_words_t words;
        int         a;
        for (a = 0; a < ALL_AXES; a++)
            words[a] = draw_word(centers[a]);
        push_sample(words, req_acc, req_gyr);
    endtask

    // Result sink: per-beat random stall, bursts with no stall, and two long
    // hold-offs so the output register fills and s_tready has to drop.
    initial
    begin : sink
        int   stall;
        int   beats;
        logic rx_burst;
        m_tready = 1'b0;
        beats    = 0;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (beats % 64 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            if (beats == 30 || beats == 250)
                stall = LONG_HOLD;
            else if (rx_burst)
                stall = 0;
            else
                stall = $urandom_range(0, 10);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            beats++;
            @(negedge clk);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: cycle limit reached, handshake stuck", $time);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : source
        imu_words_t centers;
        cal_plan_e  plan;
        int         lag;
        int         span;
        int         k;
        int         a;
        logic       ra;
        logic       rg;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        items_sent   = 0;
        sender_burst = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: corner words with zero offsets -----------------------
        // equal extremes keep their value
        push_sample({ALL_AXES{16'h7FFF}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'h7FFF}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'h8000}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'h8000}}, 1'b0, 1'b0);
        // opposite extremes: -1/2 must truncate toward zero, not floor
        push_sample({ALL_AXES{16'h7FFF}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'h8000}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'hFFFF}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'h0000}}, 1'b0, 1'b0);
        // -1 and -2 give -1, not -2
        push_sample({ALL_AXES{16'hFFFF}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'hFFFE}}, 1'b0, 1'b0);
        // every axis different, so a swapped lane shows up
        push_sample({16'hFFFE, 16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000},
                    1'b0, 1'b0);
        push_sample({16'hFFFF, 16'h0002, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF},
                    1'b0, 1'b0);
        push_sample({ALL_AXES{16'h0000}}, 1'b0, 1'b0);
        push_sample({ALL_AXES{16'h0001}}, 1'b0, 1'b0);

        // ---- directed: both calibrations start on the same beat --------------
        // gyro zeroing holds the accel step; repeated requests must be ignored
        push_sample({ALL_AXES{16'h1234}}, 1'b1, 1'b1);
        push_sample({ALL_AXES{16'h1234}}, 1'b1, 1'b1);
        push_sample({ALL_AXES{16'h8000}}, 1'b0, 1'b1);
        push_sample({ALL_AXES{16'h7FFF}}, 1'b1, 1'b0);

        // ---- random episodes ------------------------------------------------
        while (items_sent < ITEM_GOAL)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            for (a = 0; a < ALL_AXES; a++)
                centers[a] = ($urandom_range(0, 3) == 0) ? corner_words[$urandom_range(0, 3)]
                                                         : AXIS_W'($urandom);
            if ($urandom_range(0, 2) != 0)
            begin
                // calibration run long enough for both kinds to finish; small lags
                // make the gyro finish land on or next to the accel finish
                plan = cal_plan_e'($urandom_range(0, 4));
                lag  = $urandom_range(0, 5);
                span = CAL_SAMPLES + lag + $urandom_range(4, 12);
                for (k = 0; k < span && items_sent < ITEM_GOAL; k++)
                begin
                    ra = ($urandom_range(0, 49) == 0);
                    rg = ($urandom_range(0, 49) == 0);
                    case (plan)
                        PLAN_ACC:          ra = ra | (k == 0);
                        PLAN_GYR:          rg = rg | (k == 0);
                        PLAN_BOTH:
                        begin
                            ra = ra | (k == 0);
                            rg = rg | (k == 0);
                        end
                        PLAN_ACC_THEN_GYR:
                        begin
                            ra = ra | (k == 0);
                            rg = rg | (k == lag);
                        end
                        PLAN_GYR_THEN_ACC:
                        begin
                            rg = rg | (k == 0);
                            ra = ra | (k == lag);
                        end
                        default: ;
                    endcase
                    push_noisy(centers, ra, rg);
                end
            end
            else
            begin
                // free running noise, only rare stray requests
                span = $urandom_range(20, 60);
                for (k = 0; k < span && items_sent < ITEM_GOAL; k++)
                    push_noisy(centers, $urandom_range(0, 199) == 0,
                               $urandom_range(0, 199) == 0);
            end
        end

        // ---- wrap up --------------------------------------------------------
        s_tvalid <= 1'b0;
        while (means_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
